[rtl/rtsc_pkg.sv]
// shared types, constants and helpers for the resistive touch scan unit
package rtsc_pkg;

  localparam int ADC_BITS  = 12;
  localparam int PT_W      = 10;
  localparam int RES_W     = 10;
  localparam int CNT_W     = 4;
  localparam int NUM_W     = ADC_BITS + RES_W;
  localparam int DIV_CNT_W = $clog2(NUM_W);
  localparam int REG_IDX_W = 3;

  localparam logic [RES_W-1:0] HOR_RES   = RES_W'(320);
  localparam logic [RES_W-1:0] VER_RES   = RES_W'(240);
  localparam logic [CNT_W-1:0] MAX_READS = CNT_W'(10);

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_X     = 2'd1,
    OP_Y     = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ACT_X    = 2'd0,
    ACT_Y    = 2'd1,
    ACT_DONE = 2'd2,
    ACT_IGN  = 2'd3
  } action_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CAL_LEFT   = 3'd0,
    REG_CAL_RIGHT  = 3'd1,
    REG_CAL_TOP    = 3'd2,
    REG_CAL_BOTTOM = 3'd3,
    REG_X_MIN      = 3'd4,
    REG_X_MAX      = 3'd5,
    REG_Y_MIN      = 3'd6,
    REG_Y_MAX      = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_X    = 2'd1,
    PH_Y    = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_XSTART = 3'd1,
    ST_XWAIT  = 3'd2,
    ST_YSTART = 3'd3,
    ST_YWAIT  = 3'd4,
    ST_FIN    = 3'd5
  } state_t;

  typedef struct packed {
    logic [ADC_BITS-1:0] lo;
    logic [ADC_BITS-1:0] hi;
  } edge_pair_t;

  // divider request and response between sequencer and shared divider
  typedef struct packed {
    logic                start;
    logic [NUM_W-1:0]    dividend;
    logic [ADC_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quotient;
  } div_rsp_t;

  // stretch an edge pair so that it covers v
  function automatic edge_pair_t widen(input logic [ADC_BITS-1:0] v, input logic inv,
                                       input edge_pair_t e);
    edge_pair_t r;
    r = e;
    if (inv) begin
      if (v > e.lo) r.lo = v;
      else if (v < e.hi) r.hi = v;
    end else begin
      if (v < e.lo) r.lo = v;
      else if (v > e.hi) r.hi = v;
    end
    return r;
  endfunction

endpackage

[rtl/rtsc_ifs.sv]
// valid/ready channel interfaces for samples in and scan results out
interface rtsc_in_if;
  logic                          valid;
  logic                          ready;
  rtsc_pkg::op_t                 op;
  logic                          touch_sensed;
  logic [rtsc_pkg::ADC_BITS-1:0] sample;

  modport source (output valid, output op, output touch_sensed, output sample, input ready);
  modport sink (input valid, input op, input touch_sensed, input sample, output ready);
endinterface

interface rtsc_out_if;
  logic                      valid;
  logic                      ready;
  rtsc_pkg::action_t         action;
  logic                      report_valid;
  logic                      pressed;
  logic [rtsc_pkg::PT_W-1:0] point_x;
  logic [rtsc_pkg::PT_W-1:0] point_y;

  modport source (output valid, output action, output report_valid, output pressed,
                  output point_x, output point_y, input ready);
  modport sink (input valid, input action, input report_valid, input pressed,
                input point_x, input point_y, output ready);
endinterface

[rtl/rtsc_div.sv]
// shared restoring divider, one quotient bit per cycle
module rtsc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  rtsc_pkg::div_req_t req,
  output rtsc_pkg::div_rsp_t rsp
);
  import rtsc_pkg::*;

  logic [NUM_W-1:0]     dvd_r, dvd_nxt;
  logic [ADC_BITS-1:0]  rem_r, rem_nxt;
  logic [ADC_BITS-1:0]  dsr_r, dsr_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [ADC_BITS:0]    rem_sh;
  logic                 ge;

  assign rem_sh = {rem_r, dvd_r[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dvd_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      rem_nxt  = '0;
      cnt_nxt  = DIV_CNT_W'(NUM_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? ADC_BITS'(rem_sh - {1'b0, dsr_r}) : rem_sh[ADC_BITS-1:0];
      dvd_nxt = {dvd_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule

[rtl/resistive_touch_settle_calibrate_scale_unit.sv]
// top level: scan sequencer, settling, edge calibration and scaling via shared divider
// every item but a Y sample that ends its axis inside its window: result registered in the cycle after transfer
// Y sample ending its axis in its window: result via XSTART, XWAIT, YSTART, YWAIT, FIN; two 22-step divider runs
// input is not ready while a scan is being scaled or while a result waits to be taken
// synchronous active-low reset: edges load calibration defaults, held point 0, phase idle
module resistive_touch_settle_calibrate_scale_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  rtsc_in_if.sink                             in_ch,
  rtsc_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [rtsc_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [rtsc_pkg::ADC_BITS-1:0]       cfg_data
);
  import rtsc_pkg::*;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic signed [ADC_BITS:0] prev_r, prev_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ADC_BITS-1:0] settled_x_r, settled_x_nxt;
  logic [ADC_BITS-1:0] sy_r, sy_nxt;
  logic [ADC_BITS-1:0] cal_left_r, cal_left_nxt, cal_right_r, cal_right_nxt;
  logic [ADC_BITS-1:0] cal_top_r, cal_top_nxt, cal_bottom_r, cal_bottom_nxt;
  logic [ADC_BITS-1:0] x_min_r, x_min_nxt, x_max_r, x_max_nxt;
  logic [ADC_BITS-1:0] y_min_r, y_min_nxt, y_max_r, y_max_nxt;
  logic [ADC_BITS-1:0] edge_left_r, edge_left_nxt, edge_right_r, edge_right_nxt;
  logic [ADC_BITS-1:0] edge_top_r, edge_top_nxt, edge_bottom_r, edge_bottom_nxt;
  logic [PT_W-1:0]     held_x_r, held_x_nxt, held_y_r, held_y_nxt;
  logic [PT_W-1:0]     px_r, px_nxt, py_r, py_nxt;
  logic                xbad_r, xbad_nxt, ybad_r, ybad_nxt;
  logic                neg_r, neg_nxt, zspan_r, zspan_nxt;

  logic                out_valid_r, out_valid_nxt;
  action_t             out_action_r, out_action_nxt;
  logic                out_rv_r, out_rv_nxt, out_pr_r, out_pr_nxt;
  logic [PT_W-1:0]     out_px_r, out_px_nxt, out_py_r, out_py_nxt;

  logic out_free, in_fire, rel;

  // settling datapath
  logic signed [ADC_BITS:0]   samp_s;
  logic signed [ADC_BITS+1:0] diff;
  logic [ADC_BITS+1:0]        absd;
  logic [ADC_BITS:0]          sum;
  logic [CNT_W-1:0]           cnt_inc;
  logic                       settled, axis_done;
  logic [ADC_BITS-1:0]        x_val, y_val;
  edge_pair_t                 wx, wy;

  // scaling operands
  logic                       axis_y;
  logic [ADC_BITS-1:0]        op_v, op_lo, op_hi;
  logic [RES_W-1:0]           op_res;
  logic signed [ADC_BITS:0]   num, span;
  logic [ADC_BITS-1:0]        mag_num, mag_span;
  logic [PT_W-1:0]            q_sat;
  logic                       q_bad;

  div_req_t div_req;
  div_rsp_t div_rsp;

  rtsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  assign in_fire = in_ch.valid && in_ch.ready;

  assign samp_s  = signed'({1'b0, in_ch.sample});
  assign diff    = {samp_s[ADC_BITS], samp_s} - {prev_r[ADC_BITS], prev_r};
  assign absd    = diff[ADC_BITS+1] ? (ADC_BITS+2)'(-diff) : diff;
  assign settled = absd <= (ADC_BITS+2)'(in_ch.sample >> 4);
  assign cnt_inc = cnt_r + 1'b1;
  assign axis_done = settled || (cnt_inc >= MAX_READS);
  // settling only happens after a real previous sample, so prev is non-negative here
  assign sum     = {1'b0, in_ch.sample} + {1'b0, prev_r[ADC_BITS-1:0]};
  assign x_val   = settled ? sum[ADC_BITS:1] : in_ch.sample;
  assign y_val   = in_ch.sample;

  assign wx = widen(settled_x_r, cal_left_r > cal_right_r,
                    edge_pair_t'{lo: edge_left_r, hi: edge_right_r});
  assign wy = widen(y_val, cal_top_r > cal_bottom_r,
                    edge_pair_t'{lo: edge_top_r, hi: edge_bottom_r});

  assign axis_y  = (state_r == ST_YSTART);
  assign op_v    = axis_y ? sy_r : settled_x_r;
  assign op_lo   = axis_y ? edge_top_r : edge_left_r;
  assign op_hi   = axis_y ? edge_bottom_r : edge_right_r;
  assign op_res  = axis_y ? VER_RES : HOR_RES;
  assign num     = signed'({1'b0, op_v}) - signed'({1'b0, op_lo});
  assign span    = signed'({1'b0, op_hi}) - signed'({1'b0, op_lo});
  assign mag_num  = num[ADC_BITS] ? ADC_BITS'(-num) : num[ADC_BITS-1:0];
  assign mag_span = span[ADC_BITS] ? ADC_BITS'(-span) : span[ADC_BITS-1:0];

  assign div_req.start    = (state_r == ST_XSTART) || (state_r == ST_YSTART);
  assign div_req.dividend = NUM_W'(mag_num) * NUM_W'(op_res);
  assign div_req.divisor  = mag_span;

  // zero span gives 0; a non-zero quotient of mixed signs is a bad point
  assign q_sat = zspan_r ? '0 :
                 ((|div_rsp.quotient[NUM_W-1:PT_W]) ? '1 : div_rsp.quotient[PT_W-1:0]);
  assign q_bad = !zspan_r && neg_r && (div_rsp.quotient != '0);

  always_comb begin
    state_nxt       = state_r;
    phase_nxt       = phase_r;
    prev_nxt        = prev_r;
    cnt_nxt         = cnt_r;
    settled_x_nxt   = settled_x_r;
    sy_nxt          = sy_r;
    cal_left_nxt    = cal_left_r;
    cal_right_nxt   = cal_right_r;
    cal_top_nxt     = cal_top_r;
    cal_bottom_nxt  = cal_bottom_r;
    x_min_nxt       = x_min_r;
    x_max_nxt       = x_max_r;
    y_min_nxt       = y_min_r;
    y_max_nxt       = y_max_r;
    edge_left_nxt   = edge_left_r;
    edge_right_nxt  = edge_right_r;
    edge_top_nxt    = edge_top_r;
    edge_bottom_nxt = edge_bottom_r;
    held_x_nxt      = held_x_r;
    held_y_nxt      = held_y_r;
    px_nxt          = px_r;
    py_nxt          = py_r;
    xbad_nxt        = xbad_r;
    ybad_nxt        = ybad_r;
    neg_nxt         = neg_r;
    zspan_nxt       = zspan_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_action_nxt  = out_action_r;
    out_rv_nxt      = out_rv_r;
    out_pr_nxt      = out_pr_r;
    out_px_nxt      = out_px_r;
    out_py_nxt      = out_py_r;
    rel             = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          out_valid_nxt  = 1'b1;
          out_action_nxt = ACT_IGN;
          out_rv_nxt     = 1'b0;
          out_pr_nxt     = 1'b0;
          out_px_nxt     = '0;
          out_py_nxt     = '0;
          case (in_ch.op)
            OP_START: begin
              prev_nxt = '1;
              cnt_nxt  = '0;
              if (!in_ch.touch_sensed) begin
                rel = 1'b1;
              end else begin
                phase_nxt      = PH_X;
                out_action_nxt = ACT_X;
              end
            end
            OP_X: begin
              if (phase_r == PH_X) begin
                cnt_nxt = cnt_inc;
                if (!settled) prev_nxt = samp_s;
                if (!axis_done) begin
                  out_action_nxt = ACT_X;
                end else if (x_val < x_min_r || x_val > x_max_r) begin
                  rel = 1'b1;
                end else begin
                  settled_x_nxt  = x_val;
                  prev_nxt       = '1;
                  cnt_nxt        = '0;
                  phase_nxt      = PH_Y;
                  out_action_nxt = ACT_Y;
                end
              end
            end
            OP_Y: begin
              if (phase_r == PH_Y) begin
                cnt_nxt = cnt_inc;
                if (!settled) prev_nxt = samp_s;
                if (!axis_done) begin
                  out_action_nxt = ACT_Y;
                end else if (y_val < y_min_r || y_val > y_max_r) begin
                  rel = 1'b1;
                end else begin
                  // result goes out once both axes are scaled
                  out_valid_nxt   = 1'b0;
                  edge_left_nxt   = wx.lo;
                  edge_right_nxt  = wx.hi;
                  edge_top_nxt    = wy.lo;
                  edge_bottom_nxt = wy.hi;
                  sy_nxt          = y_val;
                  phase_nxt       = PH_IDLE;
                  state_nxt       = ST_XSTART;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_XSTART, ST_YSTART: begin
        neg_nxt   = num[ADC_BITS] ^ span[ADC_BITS];
        zspan_nxt = (span == '0);
        state_nxt = (state_r == ST_XSTART) ? ST_XWAIT : ST_YWAIT;
      end
      ST_XWAIT: begin
        if (div_rsp.done) begin
          px_nxt    = q_sat;
          xbad_nxt  = q_bad;
          state_nxt = ST_YSTART;
        end
      end
      ST_YWAIT: begin
        if (div_rsp.done) begin
          py_nxt    = q_sat;
          ybad_nxt  = q_bad;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (xbad_r || ybad_r) begin
            rel = 1'b1;
          end else begin
            held_x_nxt     = px_r;
            held_y_nxt     = py_r;
            out_action_nxt = ACT_DONE;
            out_rv_nxt     = 1'b1;
            out_pr_nxt     = 1'b1;
            out_px_nxt     = px_r;
            out_py_nxt     = py_r;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // released report carries the held point
    if (rel) begin
      phase_nxt      = PH_IDLE;
      out_action_nxt = ACT_DONE;
      out_rv_nxt     = 1'b1;
      out_pr_nxt     = 1'b0;
      out_px_nxt     = held_x_r;
      out_py_nxt     = held_y_r;
    end

    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_CAL_LEFT: begin
          cal_left_nxt  = cfg_data;
          edge_left_nxt = cfg_data;
        end
        REG_CAL_RIGHT: begin
          cal_right_nxt  = cfg_data;
          edge_right_nxt = cfg_data;
        end
        REG_CAL_TOP: begin
          cal_top_nxt  = cfg_data;
          edge_top_nxt = cfg_data;
        end
        REG_CAL_BOTTOM: begin
          cal_bottom_nxt  = cfg_data;
          edge_bottom_nxt = cfg_data;
        end
        REG_X_MIN: x_min_nxt = cfg_data;
        REG_X_MAX: x_max_nxt = cfg_data;
        REG_Y_MIN: y_min_nxt = cfg_data;
        REG_Y_MAX: y_max_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      prev_r        <= '1;
      cnt_r         <= '0;
      settled_x_r   <= '0;
      cal_left_r    <= '0;
      cal_right_r   <= '1;
      cal_top_r     <= '0;
      cal_bottom_r  <= '1;
      x_min_r       <= '0;
      x_max_r       <= '1;
      y_min_r       <= '0;
      y_max_r       <= '1;
      edge_left_r   <= '0;
      edge_right_r  <= '1;
      edge_top_r    <= '0;
      edge_bottom_r <= '1;
      held_x_r      <= '0;
      held_y_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      prev_r        <= prev_nxt;
      cnt_r         <= cnt_nxt;
      settled_x_r   <= settled_x_nxt;
      cal_left_r    <= cal_left_nxt;
      cal_right_r   <= cal_right_nxt;
      cal_top_r     <= cal_top_nxt;
      cal_bottom_r  <= cal_bottom_nxt;
      x_min_r       <= x_min_nxt;
      x_max_r       <= x_max_nxt;
      y_min_r       <= y_min_nxt;
      y_max_r       <= y_max_nxt;
      edge_left_r   <= edge_left_nxt;
      edge_right_r  <= edge_right_nxt;
      edge_top_r    <= edge_top_nxt;
      edge_bottom_r <= edge_bottom_nxt;
      held_x_r      <= held_x_nxt;
      held_y_r      <= held_y_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    sy_r         <= sy_nxt;
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    xbad_r       <= xbad_nxt;
    ybad_r       <= ybad_nxt;
    neg_r        <= neg_nxt;
    zspan_r      <= zspan_nxt;
    out_action_r <= out_action_nxt;
    out_rv_r     <= out_rv_nxt;
    out_pr_r     <= out_pr_nxt;
    out_px_r     <= out_px_nxt;
    out_py_r     <= out_py_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.action       = out_action_r;
  assign out_ch.report_valid = out_rv_r;
  assign out_ch.pressed      = out_pr_r;
  assign out_ch.point_x      = out_px_r;
  assign out_ch.point_y      = out_py_r;

endmodule

[rtl/rtsc_checker.sv]
// port-level checks on the touch scan unit, bound to the top level
module rtsc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input rtsc_pkg::action_t         out_action,
  input logic                      out_report_valid,
  input logic                      out_pressed,
  input logic [rtsc_pkg::PT_W-1:0] out_point_x,
  input logic [rtsc_pkg::PT_W-1:0] out_point_y
);
  import rtsc_pkg::*;

  // a report comes exactly with scan complete
  a_report_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_report_valid == (out_action == ACT_DONE)))
    else $error("report_valid does not match action");

  // non-report results carry no point
  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_report_valid) |->
      (!out_pressed && out_point_x == '0 && out_point_y == '0))
    else $error("non-report result carries point data");

  // a stalled result blocks new input
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input ready while result is stalled");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_action) && $stable(out_report_valid) &&
       $stable(out_pressed) && $stable(out_point_x) && $stable(out_point_y)))
    else $error("stalled result changed");

endmodule

bind resistive_touch_settle_calibrate_scale_unit rtsc_checker u_rtsc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_action       (out_ch.action),
  .out_report_valid (out_ch.report_valid),
  .out_pressed      (out_ch.pressed),
  .out_point_x      (out_ch.point_x),
  .out_point_y      (out_ch.point_y)
);
